FILE: rtl/ultrasonic_two_shot_ranger_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic two-shot ranger
// Concurrent property shorthands clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_TWO_SHOT_RANGER_ASSERT_SVH
`define ULTRASONIC_TWO_SHOT_RANGER_ASSERT_SVH

// same-cycle implication
`define UTSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/utsr_pkg.sv
// ----------------------------------------------------------------------------
// utsr_pkg
// Types and constants shared by the two-shot ranger modules and interfaces.
// ----------------------------------------------------------------------------
package utsr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  TRIGGER_TICKS_RST  = 8'd30;
    localparam logic [15:0] ECHO_TIMEOUT_RST   = 16'd5000;
    localparam logic [15:0] GAP_TICKS_RST      = 16'd2000;
    localparam logic [7:0]  TICKS_PER_UNIT_RST = 8'd120;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIGGER_TICKS  = 2'd0,
        REG_ECHO_TIMEOUT   = 2'd1,
        REG_GAP_TICKS      = 2'd2,
        REG_TICKS_PER_UNIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_WAIT = 3'd2,
        PH_MEAS = 3'd3,
        PH_GAP  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] echo_timeout;
        logic [15:0] gap_ticks;
        logic [7:0]  ticks_per_unit;
    } cfg_t;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic        no_object;
        logic [15:0] distance;
    } result_t;

endpackage

FILE: rtl/utsr_ifs.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface utsr_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

interface utsr_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        no_object;
    logic [15:0] distance;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output no_object, output distance, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input no_object, input distance, output ready);
endinterface

interface utsr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [utsr_pkg::CFG_INDEX_W-1:0] index;
    logic [utsr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ultrasonic_two_shot_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_two_shot_ranger
// Two-shot ultrasonic echo ranging controller with registered result output.
// ----------------------------------------------------------------------------
// Each input item is one tick (start request plus sampled echo level) and
// yields exactly one result item. An item is taken every cycle as long as the
// result register is empty or being drained; its result appears in the next cycle
// from the output register, so throughput is one item per clock while the
// output is not stalled, set by that single result register.
`include "ultrasonic_two_shot_ranger_assert.svh"

module ultrasonic_two_shot_ranger (
    input logic        clk,
    input logic        rst_n,
    utsr_in_if.sink    in_ch,
    utsr_out_if.source out_ch,
    utsr_cfg_if.sink   cfg
);
    import utsr_pkg::*;

    cfg_t     cfg_reg;
    result_t  out_reg;
    logic     out_valid_reg;
    result_t  core_res;
    in_item_t item;
    logic     in_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks  <= TRIGGER_TICKS_RST;
            cfg_reg.echo_timeout   <= ECHO_TIMEOUT_RST;
            cfg_reg.gap_ticks      <= GAP_TICKS_RST;
            cfg_reg.ticks_per_unit <= TICKS_PER_UNIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_TRIGGER_TICKS:  cfg_reg.trigger_ticks  <= cfg.data[7:0];
                REG_ECHO_TIMEOUT:   cfg_reg.echo_timeout   <= cfg.data;
                REG_GAP_TICKS:      cfg_reg.gap_ticks      <= cfg.data;
                REG_TICKS_PER_UNIT: cfg_reg.ticks_per_unit <= cfg.data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // take a new item whenever the result slot is free or leaving
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign item.start_request = in_ch.start_request;
    assign item.echo_level    = in_ch.echo_level;

    utsr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_take),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_take)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            out_reg <= core_res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.trigger_level = out_reg.trigger_level;
    assign out_ch.busy_res      = out_reg.busy_res;
    assign out_ch.done_res      = out_reg.done_res;
    assign out_ch.no_object     = out_reg.no_object;
    assign out_ch.distance      = out_reg.distance;

    `UTSR_ASSERT_NEXT(a_take_gives_result, clk, rst_n, in_ch.valid && in_ch.ready, out_ch.valid, "accepted item left no result")
    `UTSR_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken while result stalled")
    `UTSR_ASSERT_SAME(a_done_while_busy, clk, rst_n, out_ch.valid && (out_ch.done_res || out_ch.trigger_level), out_ch.busy_res, "done or trigger outside a sequence")
    `UTSR_ASSERT_SAME(a_report_needs_done, clk, rst_n, out_ch.valid && (out_ch.no_object || out_ch.distance != 16'd0), out_ch.done_res && !(out_ch.no_object && out_ch.distance != 16'd0), "report fields without done")

endmodule

FILE: rtl/utsr_core.sv
// ----------------------------------------------------------------------------
// utsr_core
// Two-shot ranging sequencer: advances one tick per accepted item and forms
// that tick's result from the current state and echo sample.
// ----------------------------------------------------------------------------
module utsr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  utsr_pkg::in_item_t item,
    input  utsr_pkg::cfg_t     cfg,
    output utsr_pkg::result_t  res
);
    import utsr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        shot_reg, shot_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  sub_reg, sub_next;
    logic [15:0] unit_reg, unit_next;
    logic [15:0] first_dist_reg, first_dist_next;
    logic        first_miss_reg, first_miss_next;

    logic [15:0] tmo;
    logic [7:0]  tpu;
    logic [7:0]  trg;
    logic [16:0] tick_inc;
    logic [8:0]  sub_inc;
    logic        end_now;
    logic        end_miss;
    logic [15:0] shot_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            shot_reg       <= 1'b0;
            tick_reg       <= '0;
            sub_reg        <= '0;
            unit_reg       <= '0;
            first_dist_reg <= '0;
            first_miss_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            shot_reg       <= shot_next;
            tick_reg       <= tick_next;
            sub_reg        <= sub_next;
            unit_reg       <= unit_next;
            first_dist_reg <= first_dist_next;
            first_miss_reg <= first_miss_next;
        end
    end

    // zero timeout, unit and trigger settings behave as one
    assign tmo = (cfg.echo_timeout == '0) ? 16'd1 : cfg.echo_timeout;
    assign tpu = (cfg.ticks_per_unit == '0) ? 8'd1 : cfg.ticks_per_unit;
    assign trg = (cfg.trigger_ticks == '0) ? 8'd1 : cfg.trigger_ticks;

    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign sub_inc  = {1'b0, sub_reg} + 9'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        shot_next       = shot_reg;
        tick_next       = tick_reg;
        sub_next        = sub_reg;
        unit_next       = unit_reg;
        first_dist_next = first_dist_reg;
        first_miss_next = first_miss_reg;
        end_now         = 1'b0;
        end_miss        = 1'b0;

        res.trigger_level = (phase_reg == PH_TRIG);
        res.busy_res      = 1'b0;
        res.done_res      = 1'b0;
        res.no_object     = 1'b0;
        res.distance      = '0;

        case (phase_reg)
            PH_TRIG:
            begin
                res.busy_res = 1'b1;
                tick_next    = tick_inc[15:0];
                if (tick_inc >= {9'd0, trg})
                begin
                    tick_next  = '0;
                    sub_next   = '0;
                    unit_next  = '0;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                res.busy_res = 1'b1;
                if (item.echo_level)
                begin
                    tick_next  = '0;
                    sub_next   = '0;
                    unit_next  = '0;
                    phase_next = PH_MEAS;
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                    if (tick_inc >= {1'b0, tmo})
                    begin
                        end_now  = 1'b1;
                        end_miss = 1'b1;
                    end
                end
            end
            PH_MEAS:
            begin
                res.busy_res = 1'b1;
                if (!item.echo_level)
                begin
                    end_now = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                    sub_next  = sub_inc[7:0];
                    if (sub_inc >= {1'b0, tpu})
                    begin
                        sub_next  = '0;
                        unit_next = unit_reg + 16'd1;
                    end
                    if (tick_inc >= {1'b0, tmo})
                    begin
                        end_now  = 1'b1;
                        end_miss = 1'b1;
                    end
                end
            end
            PH_GAP:
            begin
                res.busy_res = 1'b1;
                tick_next    = tick_inc[15:0];
                if (tick_inc >= {1'b0, cfg.gap_ticks})
                begin
                    tick_next  = '0;
                    sub_next   = '0;
                    unit_next  = '0;
                    phase_next = PH_TRIG;
                end
            end
            default:
            begin
                // idle, and any stray code behaves as idle
                phase_next = PH_IDLE;
                if (item.start_request)
                begin
                    shot_next       = 1'b0;
                    first_dist_next = '0;
                    first_miss_next = 1'b0;
                    tick_next       = '0;
                    sub_next        = '0;
                    unit_next       = '0;
                    phase_next      = PH_TRIG;
                end
            end
        endcase

        shot_dist = end_miss ? 16'd0 : unit_reg;

        if (end_now)
        begin
            tick_next = '0;
            sub_next  = '0;
            unit_next = '0;
            if (!shot_reg)
            begin
                first_miss_next = end_miss;
                first_dist_next = shot_dist;
                shot_next       = 1'b1;
                phase_next      = (cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
            end
            else
            begin
                res.done_res = 1'b1;
                if (first_miss_reg && end_miss)
                    res.no_object = 1'b1;
                else if (first_miss_reg)
                    res.distance = shot_dist;
                else if (end_miss)
                    res.distance = first_dist_reg;
                else
                    res.distance = (first_dist_reg < shot_dist) ? first_dist_reg : shot_dist;
                shot_next  = 1'b0;
                phase_next = PH_IDLE;
            end
        end
    end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Two-shot ranger testbench
// Streams tick items into the ranger and checks every result item against a
// tick-accurate prediction. Measurements are mostly well-formed two-shot
// sequences with random content, plus aborted sequences and noise.
// Configuration changes between phases, once the block is back in idle.
// ----------------------------------------------------------------------------
module tb;
    import utsr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLDOFF_LEN  = 400;
    localparam int unsigned RANDOM_TICKS = 1000;

    logic clk = 1'b0;
    logic rst_n;

    utsr_in_if  in_ch();
    utsr_out_if out_ch();
    utsr_cfg_if cfg_ch();

    ultrasonic_two_shot_ranger i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ranging state as the block should hold it
    cfg_t        ranger_cfg = {TRIGGER_TICKS_RST, ECHO_TIMEOUT_RST, GAP_TICKS_RST,
                               TICKS_PER_UNIT_RST};
    phase_t      rng_phase  = PH_IDLE;
    logic        second_shot = 1'b0;
    logic [15:0] tick_cnt   = '0;
    logic [7:0]  sub_cnt    = '0;
    logic [15:0] unit_cnt   = '0;
    logic [15:0] first_dist = '0;
    logic        first_miss = 1'b0;

    in_item_t    tick_queue[$];
    result_t     expected_results[$];
    in_item_t    next_tick;
    result_t     got_res;
    result_t     want_res;

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned done_count     = 0;
    int unsigned no_object_count = 0;
    int unsigned max_distance   = 0;
    int unsigned cfg_writes     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 19;
    int unsigned recv_idle_pct  = 77;
    int unsigned holdoff_asks   = 0;
    int unsigned holdoff_seen;
    int unsigned holdoff_left;

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // one tick of the ranger: returns the result item and advances the state
    function automatic result_t range_tick(in_item_t it);
        result_t     r;
        int unsigned tmo;
        int unsigned tpu;
        int unsigned trg;
        logic        shot_over;
        logic        missed;
        logic [15:0] d;
        tmo = at_least_one(ranger_cfg.echo_timeout);
        tpu = at_least_one(ranger_cfg.ticks_per_unit);
        trg = at_least_one(ranger_cfg.trigger_ticks);
        shot_over = 1'b0;
        missed = 1'b0;
        r = '0;
        r.trigger_level = (rng_phase == PH_TRIG);
        r.busy_res = (rng_phase != PH_IDLE);
        case (rng_phase)
            PH_IDLE:
            begin
                if (it.start_request)
                begin
                    second_shot = 1'b0;
                    first_dist = '0;
                    first_miss = 1'b0;
                    {tick_cnt, sub_cnt, unit_cnt} = '0;
                    rng_phase = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= trg)
                begin
                    {tick_cnt, sub_cnt, unit_cnt} = '0;
                    rng_phase = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (it.echo_level)
                begin
                    {tick_cnt, sub_cnt, unit_cnt} = '0;
                    rng_phase = PH_MEAS;
                end
                else
                begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= tmo)
                    begin
                        shot_over = 1'b1;
                        missed = 1'b1;
                    end
                end
            end
            PH_MEAS:
            begin
                if (!it.echo_level)
                begin
                    shot_over = 1'b1;
                end
                else
                begin
                    tick_cnt = tick_cnt + 1'b1;
                    sub_cnt = sub_cnt + 1'b1;
                    if (sub_cnt >= tpu)
                    begin
                        sub_cnt = '0;
                        unit_cnt = unit_cnt + 1'b1;
                    end
                    if (tick_cnt >= tmo)
                    begin
                        shot_over = 1'b1;
                        missed = 1'b1;
                    end
                end
            end
            default:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= ranger_cfg.gap_ticks)
                begin
                    {tick_cnt, sub_cnt, unit_cnt} = '0;
                    rng_phase = PH_TRIG;
                end
            end
        endcase
        if (shot_over)
        begin
            d = missed ? 16'd0 : unit_cnt;
            {tick_cnt, sub_cnt, unit_cnt} = '0;
            if (!second_shot)
            begin
                first_miss = missed;
                first_dist = d;
                second_shot = 1'b1;
                rng_phase = (ranger_cfg.gap_ticks == 0) ? PH_TRIG : PH_GAP;
            end
            else
            begin
                r.done_res = 1'b1;
                if (first_miss && missed)
                    r.no_object = 1'b1;
                else if (first_miss)
                    r.distance = d;
                else if (missed)
                    r.distance = first_dist;
                else
                    r.distance = (first_dist < d) ? first_dist : d;
                second_shot = 1'b0;
                rng_phase = PH_IDLE;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t: result %0d, %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    task automatic queue_tick(logic start, logic echo);
        tick_queue.push_back({start, echo});
        items_queued++;
    endtask

    // start, first shot, gap, second shot; w = echo-low ticks before the rise,
    // p = counted echo-high ticks; a value at or past the timeout is a miss
    task automatic queue_measurement(int unsigned w1, int unsigned p1,
                                     int unsigned w2, int unsigned p2);
        int unsigned trg_e;
        int unsigned tmo_e;
        int unsigned w;
        int unsigned p;
        in_item_t    last;
        trg_e = at_least_one(ranger_cfg.trigger_ticks);
        tmo_e = at_least_one(ranger_cfg.echo_timeout);
        queue_tick(1'b1, 1'($urandom_range(1)));
        for (int s = 0; s < 2; s++)
        begin
            w = (s != 0) ? w2 : w1;
            p = (s != 0) ? p2 : p1;
            if (s != 0)
                repeat (ranger_cfg.gap_ticks)
                    queue_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
            repeat (trg_e) queue_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
            if (w >= tmo_e)
            begin
                repeat (tmo_e) queue_tick($urandom_range(3) == 0, 1'b0);
            end
            else
            begin
                repeat (w) queue_tick($urandom_range(3) == 0, 1'b0);
                queue_tick($urandom_range(3) == 0, 1'b1);
                if (p >= tmo_e)
                    repeat (tmo_e) queue_tick($urandom_range(3) == 0, 1'b1);
                else
                begin
                    repeat (p) queue_tick($urandom_range(3) == 0, 1'b1);
                    queue_tick($urandom_range(3) == 0, 1'b0);
                end
            end
        end
        // start request on the done tick must be ignored
        last = tick_queue.pop_back();
        last.start_request = 1'b1;
        tick_queue.push_back(last);
    endtask

    task automatic drain();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // bring the block back to idle; alternating echo ends any wait or pulse fast
    task automatic settle();
        drain();
        while (rng_phase != PH_IDLE)
        begin
            repeat (8)
            begin
                queue_tick(1'b0, 1'b1);
                queue_tick(1'b0, 1'b0);
            end
            drain();
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_TRIGGER_TICKS:  ranger_cfg.trigger_ticks  = val[7:0];
            REG_ECHO_TIMEOUT:   ranger_cfg.echo_timeout   = val;
            REG_GAP_TICKS:      ranger_cfg.gap_ticks      = val;
            REG_TICKS_PER_UNIT: ranger_cfg.ticks_per_unit = val[7:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(int unsigned trg, int unsigned tmo, int unsigned gap,
                              int unsigned tpu);
        write_reg(REG_TRIGGER_TICKS, 16'(trg));
        write_reg(REG_ECHO_TIMEOUT, 16'(tmo));
        write_reg(REG_GAP_TICKS, 16'(gap));
        write_reg(REG_TICKS_PER_UNIT, 16'(tpu));
    endtask

    // tick driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_tick = tick_queue.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.start_request <= next_tick.start_request;
                in_ch.echo_level    <= next_tick.echo_level;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (holdoff_seen != holdoff_asks)
        begin
            holdoff_seen <= holdoff_asks;
            holdoff_left <= HOLDOFF_LEN;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted ticks, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(range_tick({in_ch.start_request,
                                                       in_ch.echo_level}));
                items_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got_res = {out_ch.trigger_level, out_ch.busy_res, out_ch.done_res,
                           out_ch.no_object, out_ch.distance};
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with none pending", 1, 0);
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (got_res.trigger_level !== want_res.trigger_level)
                        report_mismatch("trigger_level", got_res.trigger_level,
                                        want_res.trigger_level);
                    if (got_res.busy_res !== want_res.busy_res)
                        report_mismatch("busy_res", got_res.busy_res, want_res.busy_res);
                    if (got_res.done_res !== want_res.done_res)
                        report_mismatch("done_res", got_res.done_res, want_res.done_res);
                    if (got_res.no_object !== want_res.no_object)
                        report_mismatch("no_object", got_res.no_object, want_res.no_object);
                    if (got_res.distance !== want_res.distance)
                        report_mismatch("distance", got_res.distance, want_res.distance);
                    if (want_res.done_res)
                    begin
                        done_count++;
                        if (want_res.no_object)
                            no_object_count++;
                        if (want_res.distance > max_distance)
                            max_distance = want_res.distance;
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_ticks;
        int unsigned base;
        int unsigned phase_num;
        int unsigned tmo_e;
        int unsigned wlim;
        int unsigned plim;
        int unsigned w1;
        int unsigned w2;
        int unsigned p1;
        int unsigned p2;
        int unsigned r;

        in_ch.valid = 1'b0;
        in_ch.start_request = 1'b0;
        in_ch.echo_level = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_TRIGGER_TICKS;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: hit then wait miss, pulse miss then wait miss, idle noise
        set_config(1, 3, 1, 1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_measurement(1, 2, 3, 0);
        queue_measurement(0, 3, 3, 0);
        settle();
        // all-zero settings: one-tick trigger, timeout and unit, no gap
        set_config(0, 0, 0, 0);
        queue_measurement(0, 0, 1, 0);
        queue_measurement(0, 1, 0, 0);
        settle();

        random_ticks = 0;
        phase_num = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            if (random_ticks < RANDOM_TICKS / 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 77;
            end
            else if (random_ticks < 2 * RANDOM_TICKS / 3)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = $urandom_range(9);
            w1 = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 6);
            r = $urandom_range(9);
            w2 = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 40);
            r = $urandom_range(9);
            p1 = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 8);
            set_config(w1, w2, ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12), p1);

            tmo_e = at_least_one(ranger_cfg.echo_timeout);
            wlim = (tmo_e < 40) ? tmo_e : 40;
            plim = (tmo_e < 80) ? tmo_e : 80;
            // stall results while ticks keep coming so the input backs up
            if (phase_num == 0)
                holdoff_asks++;
            base = items_queued;
            repeat ($urandom_range(4, 10))
            begin
                if ($urandom_range(9) == 0)
                begin
                    // aborted sequence: start, then random levels, then recover
                    queue_tick(1'b1, 1'($urandom_range(1)));
                    repeat ($urandom_range(3, 30))
                        queue_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
                    random_ticks += items_queued - base;
                    settle();
                    base = items_queued;
                end
                else
                begin
                    w1 = ($urandom_range(4) == 0 && tmo_e <= 300) ? tmo_e
                                                                   : $urandom_range(0, wlim - 1);
                    w2 = ($urandom_range(4) == 0 && tmo_e <= 300) ? tmo_e
                                                                   : $urandom_range(0, wlim - 1);
                    p1 = ($urandom_range(5) == 0 && tmo_e <= 300) ? tmo_e
                                                                   : $urandom_range(0, plim - 1);
                    p2 = ($urandom_range(5) == 0 && tmo_e <= 300) ? tmo_e
                                                                   : $urandom_range(0, plim - 1);
                    queue_measurement(w1, p1, w2, p2);
                    if ($urandom_range(3) == 0)
                        repeat ($urandom_range(1, 6)) queue_tick(1'b0, 1'($urandom_range(1)));
                end
            end
            random_ticks += items_queued - base;
            settle();
            phase_num++;
        end

        // largest trigger, timeout and unit settings, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(255, 65535, 40, 255);
        queue_measurement(3, 300, 10, 260);
        settle();

        drain();
        repeat (10) @(posedge clk);
        $display("%0d ticks checked in %0d config phases (%0d register writes)",
                 results_seen, phase_num + 3, cfg_writes);
        $display("%0d measurements completed, %0d with no object, largest distance %0d",
                 done_count, no_object_count, max_distance);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/utsr_pkg.sv
rtl/utsr_ifs.sv
rtl/utsr_core.sv
rtl/ultrasonic_two_shot_ranger.sv
dv/tb.sv
